// ===== rtl/core/kvtp_pkg.sv =====
// Package for the key/value token parser.
// Holds character codes, status codes, the phase encoding and the result types.
// Depends on nothing.
`default_nettype none

package kvtp_pkg;

  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LC_N   = 8'h6E;
  localparam logic [7:0] CH_LC_R   = 8'h72;
  localparam logic [7:0] CH_LC_T   = 8'h74;
  localparam logic [7:0] CH_LC_B   = 8'h62;
  localparam logic [7:0] CH_LC_F   = 8'h66;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_KEY   = 2'd1;
  localparam logic [1:0] ST_OPEN     = 2'd2;
  localparam logic [1:0] ST_DANGLING = 2'd3;

  typedef enum logic [6:0] {
    PH_SKIP_KEY = 7'b0000001,
    PH_KEY      = 7'b0000010,
    PH_SKIP_VAL = 7'b0000100,
    PH_UNQUOTED = 7'b0001000,
    PH_QUOTED   = 7'b0010000,
    PH_ESCAPE   = 7'b0100000,
    PH_DISCARD  = 7'b1000000
  } kvtp_phase_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       byte_in_value;
    logic       item_done;
    logic       item_has_value;
    logic [1:0] parse_status;
    logic       last_of_run;
  } kvtp_result_t;

  typedef struct packed {
    logic [1:0]   count;
    kvtp_result_t r0;
    kvtp_result_t r1;
    kvtp_phase_t  phase_next;
  } kvtp_step_t;

endpackage

`default_nettype wire

// ===== rtl/core/kvtp_decode.sv =====
// Per-byte decode logic of the key/value token parser.
// Maps the current phase and one input byte to up to two results and the next phase.
// Depends on kvtp_pkg.
`default_nettype none

module kvtp_decode
  import kvtp_pkg::*;
(
  input  kvtp_phase_t phase,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  input  logic        value_to_line_end,
  output kvtp_step_t  step
);

  function automatic kvtp_result_t mk(input logic [7:0] b, input logic valid,
                                      input logic inval, input logic done,
                                      input logic hasval, input logic [1:0] status);
    kvtp_result_t r;
    r.out_byte       = valid ? b : 8'd0;
    r.byte_valid     = valid;
    r.byte_in_value  = valid & inval;
    r.item_done      = done;
    r.item_has_value = done & hasval;
    r.parse_status   = status;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  logic [7:0]  delim;
  logic [7:0]  esc_char;
  logic        esc_known;
  kvtp_phase_t nxt;
  logic        eot;
  logic [7:0]  c;

  assign c     = text_byte;
  assign eot   = end_of_text;
  assign delim = value_to_line_end ? CH_NL : CH_SPACE;

  always_comb begin
    esc_known = 1'b1;
    esc_char  = c;
    case (c)
      CH_QUOTE, CH_BSLASH: esc_char = c;
      CH_LC_N: esc_char = CH_NL;
      CH_LC_R: esc_char = CH_CR;
      CH_LC_T: esc_char = CH_TAB;
      CH_LC_B: esc_char = CH_BS;
      CH_LC_F: esc_char = CH_FF;
      default: esc_known = 1'b0;
    endcase
  end

  always_comb begin
    step.count = 2'd0;
    step.r0    = '0;
    step.r1    = '0;
    nxt        = phase;
    case (phase)
      PH_SKIP_KEY: begin
        if (c == CH_SPACE) begin
          if (eot) begin
            step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, ST_NO_KEY);
            step.count = 2'd1;
          end
        end else if (c == CH_COLON) begin
          step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, ST_NO_KEY);
          step.count = 2'd1;
          nxt = PH_DISCARD;
        end else begin
          step.r0 = mk(c, 1'b1, 1'b0, eot, 1'b0, ST_OK);
          step.count = 2'd1;
          nxt = PH_KEY;
        end
      end
      PH_KEY: begin
        if (c == CH_SPACE) begin
          step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK);
          step.count = 2'd1;
          nxt = PH_SKIP_KEY;
        end else if (c == CH_COLON) begin
          if (eot) begin
            step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK);
            step.count = 2'd1;
          end
          nxt = PH_SKIP_VAL;
        end else begin
          step.r0 = mk(c, 1'b1, 1'b0, eot, 1'b0, ST_OK);
          step.count = 2'd1;
        end
      end
      PH_SKIP_VAL: begin
        if (c == CH_SPACE) begin
          if (eot) begin
            step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK);
            step.count = 2'd1;
          end
        end else if (c == CH_QUOTE) begin
          if (eot) begin
            step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, ST_OPEN);
            step.count = 2'd1;
          end
          nxt = PH_QUOTED;
        end else if (c == delim) begin
          step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK);
          step.count = 2'd1;
          nxt = PH_SKIP_KEY;
        end else begin
          step.r0 = mk(c, 1'b1, 1'b1, eot, 1'b1, ST_OK);
          step.count = 2'd1;
          nxt = PH_UNQUOTED;
        end
      end
      PH_UNQUOTED: begin
        if (c == delim) begin
          step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK);
          step.count = 2'd1;
          nxt = PH_SKIP_KEY;
        end else begin
          step.r0 = mk(c, 1'b1, 1'b1, eot, 1'b1, ST_OK);
          step.count = 2'd1;
        end
      end
      PH_QUOTED: begin
        if (c == CH_QUOTE) begin
          step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK);
          step.count = 2'd1;
          nxt = PH_SKIP_KEY;
        end else if (c == CH_BSLASH) begin
          if (eot) begin
            step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, ST_DANGLING);
            step.count = 2'd1;
          end
          nxt = PH_ESCAPE;
        end else if (eot) begin
          step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, ST_OPEN);
          step.count = 2'd1;
        end else begin
          step.r0 = mk(c, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
          step.count = 2'd1;
        end
      end
      PH_ESCAPE: begin
        if (eot) begin
          step.r0 = mk(8'd0, 1'b0, 1'b0, 1'b0, 1'b0, ST_OPEN);
          step.count = 2'd1;
        end else if (esc_known) begin
          step.r0 = mk(esc_char, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
          step.count = 2'd1;
        end else begin
          step.r0 = mk(CH_BSLASH, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
          step.r1 = mk(c, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK);
          step.count = 2'd2;
        end
        nxt = PH_QUOTED;
      end
      default: begin
        nxt = phase;
      end
    endcase
    step.r0.last_of_run = (step.count == 2'd1);
    step.r1.last_of_run = (step.count == 2'd2);
    step.phase_next = eot ? PH_SKIP_KEY : nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/key_value_token_parser.sv =====
// Top level of the key/value token parser.
// Input register, per-byte decode and a four-entry result queue.
// Depends on kvtp_pkg and kvtp_decode.
//
// The input channel carries one text byte per item with an end-of-text
// flag; an item is taken at a clock edge where in_valid is high and
// in_stall is low. Each item causes zero, one or two result items on the
// output channel, taken where out_valid is high and out_stall is low.
// The configuration channel writes value_to_line_end through cfg_data
// when cfg_valid is high; cfg_ready is always high.
// An accepted item is held in the input register and, while the queue
// has room, is decoded into the result queue, where its first result,
// if any, appears and out_valid goes high.
// Throughput is one item per cycle while the queue has room. An unknown
// escape inside quotes gives two results, but the backslash before it
// gives none, so a free receiver keeps up; in_stall rises only while the
// queue holds three or more results and the input register is occupied.
// When the receiver stalls, the head result holds and the queue fills,
// then the input side stalls. Reset empties the queue and the input
// register, clears the line-mode register and returns to skipping spaces
// before a key.
`default_nettype none

module key_value_token_parser
  import kvtp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       byte_in_value,
  output logic       item_done,
  output logic       item_has_value,
  output logic [1:0] parse_status,
  output logic       last_of_run
);

  localparam int QDepth = 4;
  localparam int PtrW   = $clog2(QDepth);
  localparam int CntW   = $clog2(QDepth + 1);

  logic                value_to_line_end;
  kvtp_phase_t         phase;
  logic                s1_valid;
  logic [7:0]          s1_byte;
  logic                s1_eot;
  kvtp_result_t        queue [QDepth];
  logic [PtrW-1:0]     wr_ptr;
  logic [PtrW-1:0]     rd_ptr;
  logic [CntW-1:0]     count;
  logic [CntW-1:0]     count_next;
  logic [CntW-1:0]     push_n;
  logic                room;
  logic                advance;
  logic                accept;
  logic                pop;
  kvtp_step_t          step;
  kvtp_result_t        head;

  kvtp_decode u_decode (
    .phase             (phase),
    .text_byte         (s1_byte),
    .end_of_text       (s1_eot),
    .value_to_line_end (value_to_line_end),
    .step              (step)
  );

  assign cfg_ready  = 1'b1;
  assign room       = (count <= CntW'(QDepth - 2));
  assign advance    = s1_valid & room;
  assign in_stall   = s1_valid & ~room;
  assign accept     = in_valid & ~in_stall;
  assign out_valid  = (count != '0);
  assign pop        = out_valid & ~out_stall;
  assign push_n     = advance ? CntW'(step.count) : '0;
  assign count_next = count - CntW'(pop) + push_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      value_to_line_end <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      value_to_line_end <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept | (s1_valid & ~advance);
    end
    if (accept) begin
      s1_byte <= text_byte;
      s1_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_SKIP_KEY;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (pop) begin
        rd_ptr <= rd_ptr + PtrW'(1);
      end
      if (advance) begin
        phase  <= step.phase_next;
        wr_ptr <= wr_ptr + PtrW'(step.count);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.count != 2'd0) begin
      queue[wr_ptr] <= step.r0;
    end
    if (advance && step.count == 2'd2) begin
      queue[wr_ptr + PtrW'(1)] <= step.r1;
    end
  end

  assign head           = queue[rd_ptr];
  assign out_byte       = head.out_byte;
  assign byte_valid     = head.byte_valid;
  assign byte_in_value  = head.byte_in_value;
  assign item_done      = head.item_done;
  assign item_has_value = head.item_has_value;
  assign parse_status   = head.parse_status;
  assign last_of_run    = head.last_of_run;

endmodule

`default_nettype wire

// ===== rtl/core/kvtp_checker.sv =====
// Port-level checker for the key/value token parser, with its bind.
// Watches the output channel of key_value_token_parser.
// Depends on kvtp_pkg.
`default_nettype none

module kvtp_checker
  import kvtp_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       byte_in_value,
  input logic       item_done,
  input logic       item_has_value,
  input logic [1:0] parse_status
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(item_done))
    else $error("stalled result changed");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> out_byte == 8'd0 && !byte_in_value)
    else $error("empty result carries byte data");

  a_value_needs_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && item_has_value |-> item_done)
    else $error("item_has_value without item_done");

  a_error_alone: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_status != ST_OK |-> !byte_valid && !item_done)
    else $error("error result carries a byte or item end");

endmodule

bind key_value_token_parser kvtp_checker u_kvtp_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte       (out_byte),
  .byte_valid     (byte_valid),
  .byte_in_value  (byte_in_value),
  .item_done      (item_done),
  .item_has_value (item_has_value),
  .parse_status   (parse_status)
);

`default_nettype wire

// ===== bench/tb_key_value_token_parser.sv =====
// Self-checking testbench for key_value_token_parser: a directed table, then random texts.
// Expected results come from a behavioral parser kept inside the bench, under random stalls.
// Depends on kvtp_pkg and the key_value_token_parser RTL.
`timescale 1ns / 1ps

module tb_key_value_token_parser
  import kvtp_pkg::*;
();

  typedef struct packed {
    logic [7:0]   ch;
    logic         eot;
    logic         typed;
    logic [1:0]   n_typed;
    kvtp_result_t typed_res;
  } text_row_t;

  localparam kvtp_result_t NO_TOKEN       = '0;
  localparam kvtp_result_t NO_KEY_TOKEN   = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_NO_KEY, 1'b1};
  localparam kvtp_result_t OPEN_TOKEN     = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OPEN, 1'b1};
  localparam kvtp_result_t DANGLING_TOKEN = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_DANGLING, 1'b1};
  localparam int PHASE_ITEMS = 376;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       cfg_data = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] text_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       byte_in_value;
  logic       item_done;
  logic       item_has_value;
  logic [1:0] parse_status;
  logic       last_of_run;

  kvtp_result_t pending_tokens[$];
  kvtp_phase_t  tok_phase = PH_SKIP_KEY;
  logic         line_mode = 1'b0;
  logic         quiet_text = 1'b0;
  int           error_count = 0;
  int           holds_asked = 0;
  int           holds_done = 0;
  int           hold_left = 0;
  int           run_left = 0;
  text_row_t    directed_rows[25];

  key_value_token_parser dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .text_byte(text_byte), .end_of_text(end_of_text),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .byte_valid(byte_valid), .byte_in_value(byte_in_value),
    .item_done(item_done), .item_has_value(item_has_value),
    .parse_status(parse_status), .last_of_run(last_of_run)
  );

  always #10 clk = ~clk;

  initial begin
    #20_000_000;
    $display("key_value_token_parser verification failed");
    $finish;
  end

  function automatic kvtp_result_t make_token(input logic [7:0] b, input logic v,
                                              input logic iv, input logic d,
                                              input logic hv, input logic [1:0] st);
    kvtp_result_t t;
    t.out_byte       = v ? b : 8'h00;
    t.byte_valid     = v;
    t.byte_in_value  = v ? iv : 1'b0;
    t.item_done      = d;
    t.item_has_value = d ? hv : 1'b0;
    t.parse_status   = st;
    t.last_of_run    = 1'b0;
    return t;
  endfunction

  task automatic tokenize_byte(input logic [7:0] ch, input logic eot,
                               output kvtp_result_t produced[$]);
    logic [7:0]  delim;
    logic [7:0]  dec;
    logic        known;
    kvtp_phase_t nxt;
    delim = line_mode ? CH_NL : CH_SPACE;
    nxt = tok_phase;
    produced.delete();
    case (tok_phase)
      PH_SKIP_KEY: begin
        if (ch == CH_SPACE) begin
          if (eot) produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_NO_KEY));
        end else if (ch == CH_COLON) begin
          produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_NO_KEY));
          nxt = PH_DISCARD;
        end else begin
          produced.push_back(make_token(ch, 1'b1, 1'b0, eot, 1'b0, ST_OK));
          nxt = PH_KEY;
        end
      end
      PH_KEY: begin
        if (ch == CH_SPACE) begin
          produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b0, ST_OK));
          nxt = PH_SKIP_KEY;
        end else if (ch == CH_COLON) begin
          if (eot) produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK));
          nxt = PH_SKIP_VAL;
        end else begin
          produced.push_back(make_token(ch, 1'b1, 1'b0, eot, 1'b0, ST_OK));
        end
      end
      PH_SKIP_VAL: begin
        if (ch == CH_SPACE) begin
          if (eot) produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK));
        end else if (ch == CH_QUOTE) begin
          if (eot) produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OPEN));
          nxt = PH_QUOTED;
        end else if (ch == delim) begin
          produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK));
          nxt = PH_SKIP_KEY;
        end else begin
          produced.push_back(make_token(ch, 1'b1, 1'b1, eot, 1'b1, ST_OK));
          nxt = PH_UNQUOTED;
        end
      end
      PH_UNQUOTED: begin
        if (ch == delim) begin
          produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK));
          nxt = PH_SKIP_KEY;
        end else begin
          produced.push_back(make_token(ch, 1'b1, 1'b1, eot, 1'b1, ST_OK));
        end
      end
      PH_QUOTED: begin
        if (ch == CH_QUOTE) begin
          produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b1, 1'b1, ST_OK));
          nxt = PH_SKIP_KEY;
        end else if (ch == CH_BSLASH) begin
          if (eot) produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_DANGLING));
          nxt = PH_ESCAPE;
        end else if (eot) begin
          produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OPEN));
        end else begin
          produced.push_back(make_token(ch, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK));
        end
      end
      PH_ESCAPE: begin
        known = 1'b1;
        case (ch)
          CH_QUOTE, CH_BSLASH: dec = ch;
          CH_LC_N: dec = CH_NL;
          CH_LC_R: dec = CH_CR;
          CH_LC_T: dec = CH_TAB;
          CH_LC_B: dec = CH_BS;
          CH_LC_F: dec = CH_FF;
          default: begin
            dec = ch;
            known = 1'b0;
          end
        endcase
        if (eot) begin
          produced.push_back(make_token(8'h00, 1'b0, 1'b0, 1'b0, 1'b0, ST_OPEN));
        end else if (known) begin
          produced.push_back(make_token(dec, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK));
        end else begin
          produced.push_back(make_token(CH_BSLASH, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK));
          produced.push_back(make_token(ch, 1'b1, 1'b1, 1'b0, 1'b0, ST_OK));
        end
        nxt = PH_QUOTED;
      end
      default: begin
      end
    endcase
    tok_phase = eot ? PH_SKIP_KEY : nxt;
    if (produced.size() > 0) produced[produced.size() - 1].last_of_run = 1'b1;
  endtask

  function automatic int pick_gap();
    int r;
    if (quiet_text) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  task automatic send_item(input logic [7:0] ch, input logic eot, input logic typed,
                           input logic [1:0] n_typed, input kvtp_result_t typed_res);
    int gap;
    kvtp_result_t produced[$];
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    text_byte <= ch;
    end_of_text <= eot;
    do @(posedge clk); while (in_stall);
    tokenize_byte(ch, eot, produced);
    if (typed) begin
      produced.delete();
      if (n_typed != 0) produced.push_back(typed_res);
    end
    foreach (produced[i]) pending_tokens.push_back(produced[i]);
  endtask

  task automatic drain_tokens();
    in_valid <= 1'b0;
    while (pending_tokens.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_line_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    line_mode = mode;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] draw_byte_except(input logic [7:0] a, input logic [7:0] b,
                                                  input logic [7:0] c);
    logic [7:0] v;
    do v = 8'($urandom_range(0, 255)); while (v == a || v == b || v == c);
    return v;
  endfunction

  function automatic logic [7:0] pick_escape();
    case ($urandom_range(0, 7))
      0: return CH_LC_N;
      1: return CH_LC_R;
      2: return CH_LC_T;
      3: return CH_LC_B;
      4: return CH_LC_F;
      5: return CH_QUOTE;
      6: return CH_BSLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic compose_text(output logic [7:0] txt[$]);
    logic [7:0] delim;
    logic [7:0] sep;
    int kind;
    int keep;
    txt.delete();
    delim = line_mode ? CH_NL : CH_SPACE;
    if ($urandom_range(0, 99) < 12) begin
      repeat ($urandom_range(1, 12)) txt.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(1, 4)) begin
      repeat ($urandom_range(0, 2)) txt.push_back(CH_SPACE);
      repeat ($urandom_range(1, 5)) txt.push_back(draw_byte_except(CH_SPACE, CH_COLON, CH_COLON));
      sep = CH_SPACE;
      if ($urandom_range(0, 99) < 70) begin
        txt.push_back(CH_COLON);
        repeat ($urandom_range(0, 2)) txt.push_back(CH_SPACE);
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          txt.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 99) < 30) begin
              txt.push_back(CH_BSLASH);
              txt.push_back(pick_escape());
            end else begin
              txt.push_back(draw_byte_except(CH_QUOTE, CH_BSLASH, CH_BSLASH));
            end
          end
          if ($urandom_range(0, 99) < 92) txt.push_back(CH_QUOTE);
        end else if (kind < 90) begin
          txt.push_back(draw_byte_except(CH_SPACE, CH_QUOTE, delim));
          repeat ($urandom_range(0, 4)) txt.push_back(draw_byte_except(delim, delim, delim));
          sep = delim;
        end
      end
      txt.push_back(sep);
    end
    if ($urandom_range(0, 99) < 60) void'(txt.pop_back());
    if ($urandom_range(0, 99) < 8) begin
      keep = $urandom_range(1, txt.size());
      while (txt.size() > keep) void'(txt.pop_back());
    end
  endtask

  task automatic compare_field(input string name, input int expv, input int actv);
    if (expv != actv) begin
      error_count++;
      if (error_count <= 100)
        $display("%0t: %s expected %0d, got %0d", $time, name, expv, actv);
    end
  endtask

  always @(posedge clk) begin
    kvtp_result_t exp_tok;
    if (!rst && out_valid && !out_stall) begin
      if (pending_tokens.size() == 0) begin
        error_count++;
        $display("%0t: result with none expected, got byte %0d status %0d",
                 $time, out_byte, parse_status);
      end else begin
        exp_tok = pending_tokens.pop_front();
        compare_field("out_byte", int'(exp_tok.out_byte), int'(out_byte));
        compare_field("byte_valid", int'(exp_tok.byte_valid), int'(byte_valid));
        compare_field("byte_in_value", int'(exp_tok.byte_in_value), int'(byte_in_value));
        compare_field("item_done", int'(exp_tok.item_done), int'(item_done));
        compare_field("item_has_value", int'(exp_tok.item_has_value),
                      int'(item_has_value));
        compare_field("parse_status", int'(exp_tok.parse_status), int'(parse_status));
        compare_field("last_of_run", int'(exp_tok.last_of_run), int'(last_of_run));
      end
    end
  end

  always @(posedge clk) begin
    if (holds_done < holds_asked) begin
      hold_left = 80;
      holds_done++;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (run_left > 0) begin
      run_left--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9: begin
          out_stall <= 1'b0;
          run_left = $urandom_range(0, 20);
        end
        10: begin
          out_stall <= 1'b0;
          run_left = $urandom_range(30, 60);
        end
        19: begin
          out_stall <= 1'b1;
          run_left = $urandom_range(10, 40);
        end
        default: begin
          out_stall <= 1'b1;
          run_left = $urandom_range(0, 3);
        end
      endcase
    end
  end

  initial begin
    logic [7:0] txt[$];
    logic       phase_modes[5];
    int         sent;
    phase_modes = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    directed_rows = '{
      '{CH_SPACE,  1'b1, 1'b1, 2'd1, NO_KEY_TOKEN},
      '{CH_COLON,  1'b0, 1'b1, 2'd1, NO_KEY_TOKEN},
      '{8'h78,     1'b1, 1'b1, 2'd0, NO_TOKEN},
      '{8'hFF,     1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_COLON,  1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_QUOTE,  1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_LC_N,   1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{8'h71,     1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_QUOTE,  1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{8'h00,     1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_QUOTE,  1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{8'h61,     1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_COLON,  1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{8'h76,     1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_SPACE,  1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{8'h62,     1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_COLON,  1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_QUOTE,  1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_BSLASH, 1'b1, 1'b1, 2'd1, DANGLING_TOKEN},
      '{8'h63,     1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_COLON,  1'b0, 1'b0, 2'd0, NO_TOKEN},
      '{CH_QUOTE,  1'b1, 1'b1, 2'd1, OPEN_TOKEN}
    };
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    write_line_mode(1'b0);
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].ch, directed_rows[i].eot, directed_rows[i].typed,
                directed_rows[i].n_typed, directed_rows[i].typed_res);
    end
    for (int ph = 0; ph < 5; ph++) begin
      drain_tokens();
      write_line_mode(phase_modes[ph]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        compose_text(txt);
        quiet_text = ($urandom_range(0, 3) == 0);
        foreach (txt[i]) begin
          if (ph % 2 == 1 && sent == 150) holds_asked++;
          if (ph == 2 && sent == 190) drain_tokens();
          send_item(txt[i], i == txt.size() - 1, 1'b0, 2'd0, NO_TOKEN);
          sent++;
        end
      end
    end
    drain_tokens();
    if (error_count == 0) begin
      $display("key_value_token_parser verification clean");
    end else begin
      $display("key_value_token_parser verification failed");
    end
    $finish;
  end

endmodule
